### rtl/rld_pkg.sv
// shared constants, codes and control types of the run-length decode iterator
package rld_pkg;

  localparam int MAX_RUNS = 64;
  localparam int IDX_W    = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);
  localparam int DATA_W   = 31;
  localparam int STAT_W   = 2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_LOAD_OK   = 2'd0,
    STAT_LOAD_FULL = 2'd1,
    STAT_VALUE     = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_write;
    logic load_full;
    logic exhaust;
    logic skip;
    logic hit;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_consume;
    logic full;
    logic exhausted;
    logic need_gt;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/rld_in_if.sv
// input channel: load or consume requests
interface rld_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [rld_pkg::DATA_W-1:0] run_count;
  logic [rld_pkg::DATA_W-1:0] run_value;
  logic [rld_pkg::DATA_W-1:0] take_amount;

  modport source (output valid, output cmd, output run_count, output run_value,
                  output take_amount, input ready);
  modport sink (input valid, input cmd, input run_count, input run_value,
                input take_amount, output ready);
endinterface

### rtl/rld_out_if.sv
// result channel: status and element value
interface rld_out_if;
  logic                       valid;
  logic                       ready;
  logic [rld_pkg::STAT_W-1:0] status;
  logic [rld_pkg::DATA_W-1:0] element_value;

  modport source (output valid, output status, output element_value, input ready);
  modport sink (input valid, input status, input element_value, output ready);
endinterface

### rtl/rld_ram.sv
// generic single write, single read ram with registered read data
module rld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rld_ctrl.sv
// controller state machine sequencing loads, run skips and result transfers
module rld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rld_pkg::dp_stat_t stat,
  output rld_pkg::dp_cmd_t  cmd
);

  rld_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rld_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rld_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = rld_pkg::ST_EXEC;
        end
      end
      rld_pkg::ST_EXEC: begin
        if (!stat.is_consume) begin
          if (stat.full) begin
            cmd.load_full = 1'b1;
          end else begin
            cmd.load_write = 1'b1;
          end
          state_nxt = rld_pkg::ST_RESP;
        end else if (stat.exhausted) begin
          cmd.exhaust = 1'b1;
          state_nxt   = rld_pkg::ST_RESP;
        end else begin
          state_nxt = rld_pkg::ST_CHECK;
        end
      end
      rld_pkg::ST_CHECK: begin
        if (stat.need_gt) begin
          cmd.skip  = 1'b1;
          state_nxt = rld_pkg::ST_EXEC;
        end else begin
          cmd.hit   = 1'b1;
          state_nxt = rld_pkg::ST_RESP;
        end
      end
      rld_pkg::ST_RESP: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = rld_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rld_pkg::ST_IDLE;
    endcase
  end

  a_check_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rld_pkg::ST_CHECK) |-> ($past(state_r) == rld_pkg::ST_EXEC))
    else $error("check state entered without a read cycle");

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result issued into an occupied output register");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == rld_pkg::ST_IDLE))
    else $error("controller not idle after result transfer");

endmodule

### rtl/rld_dp.sv
// datapath: run tables, run pointers, remaining amount and output register
module rld_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_cmd,
  input  logic [rld_pkg::DATA_W-1:0]  in_run_count,
  input  logic [rld_pkg::DATA_W-1:0]  in_run_value,
  input  logic [rld_pkg::DATA_W-1:0]  in_take_amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rld_pkg::STAT_W-1:0]  out_status,
  output logic [rld_pkg::DATA_W-1:0]  out_element_value,
  input  rld_pkg::dp_cmd_t            cmd,
  output rld_pkg::dp_stat_t           stat
);

  logic                       cmd_r;
  logic [rld_pkg::DATA_W-1:0] run_count_r;
  logic [rld_pkg::DATA_W-1:0] run_value_r;
  logic [rld_pkg::DATA_W-1:0] need_r;
  logic [rld_pkg::CNT_W-1:0]  runs_loaded_r;
  logic [rld_pkg::CNT_W-1:0]  current_run_r;
  rld_pkg::status_t           res_status_r;
  logic [rld_pkg::DATA_W-1:0] res_value_r;
  logic                       out_valid_r;
  logic [rld_pkg::STAT_W-1:0] out_status_r;
  logic [rld_pkg::DATA_W-1:0] out_value_r;

  logic                       cnt_we;
  logic [rld_pkg::IDX_W-1:0]  cnt_wr_addr;
  logic [rld_pkg::DATA_W-1:0] cnt_wr_data;
  logic [rld_pkg::DATA_W-1:0] cnt_rd;
  logic [rld_pkg::DATA_W-1:0] val_rd;
  logic [rld_pkg::IDX_W-1:0]  cur_idx;
  logic [rld_pkg::IDX_W-1:0]  load_idx;

  assign cur_idx  = current_run_r[rld_pkg::IDX_W-1:0];
  assign load_idx = runs_loaded_r[rld_pkg::IDX_W-1:0];

  assign cnt_we      = cmd.load_write | cmd.hit;
  assign cnt_wr_addr = cmd.load_write ? load_idx : cur_idx;
  assign cnt_wr_data = cmd.load_write ? run_count_r : (cnt_rd - need_r);

  rld_ram #(.WIDTH(rld_pkg::DATA_W), .DEPTH(rld_pkg::MAX_RUNS)) u_count_ram (
    .clk     (clk),
    .we      (cnt_we),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_addr (cur_idx),
    .rd_data (cnt_rd)
  );

  rld_ram #(.WIDTH(rld_pkg::DATA_W), .DEPTH(rld_pkg::MAX_RUNS)) u_value_ram (
    .clk     (clk),
    .we      (cmd.load_write),
    .wr_addr (load_idx),
    .wr_data (run_value_r),
    .rd_addr (cur_idx),
    .rd_data (val_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r       <= in_cmd;
      run_count_r <= in_run_count;
      run_value_r <= in_run_value;
      need_r      <= in_take_amount;
    end else if (cmd.skip) begin
      need_r <= need_r - cnt_rd;
    end

    if (cmd.load_write) begin
      res_status_r <= rld_pkg::STAT_LOAD_OK;
      res_value_r  <= '0;
    end else if (cmd.load_full) begin
      res_status_r <= rld_pkg::STAT_LOAD_FULL;
      res_value_r  <= '0;
    end else if (cmd.exhaust) begin
      res_status_r <= rld_pkg::STAT_EXHAUSTED;
      res_value_r  <= '0;
    end else if (cmd.hit) begin
      res_status_r <= rld_pkg::STAT_VALUE;
      res_value_r  <= val_rd;
    end

    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      runs_loaded_r <= '0;
      current_run_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.load_write) begin
        runs_loaded_r <= runs_loaded_r + rld_pkg::CNT_W'(1);
      end
      if (cmd.skip) begin
        current_run_r <= current_run_r + rld_pkg::CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.is_consume = (cmd_r == rld_pkg::CMD_CONSUME);
  assign stat.full       = (runs_loaded_r == rld_pkg::CNT_W'(rld_pkg::MAX_RUNS));
  assign stat.exhausted  = (current_run_r >= runs_loaded_r);
  assign stat.need_gt    = (need_r > cnt_rd);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_value = out_value_r;

  a_cur_within_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    current_run_r <= runs_loaded_r)
    else $error("current run beyond loaded runs");

  a_loaded_within_table: assert property (@(posedge clk) disable iff (!rst_n)
    runs_loaded_r <= rld_pkg::CNT_W'(rld_pkg::MAX_RUNS))
    else $error("run count beyond table size");

  a_skip_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.skip |=> (current_run_r == $past(current_run_r) + rld_pkg::CNT_W'(1)))
    else $error("skip did not advance current run");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hit || cmd.skip) |-> (current_run_r < runs_loaded_r))
    else $error("run read outside loaded runs");

endmodule

### rtl/run_length_decode_iterator_core.sv
// top level of the run-length decode iterator
// a load goes from idle through exec to resp, where it waits for a free output register
// a consume repeats exec and check per skipped run, then goes to resp on a hit or on exhaustion
// one request at a time: the next is taken only once the last result enters the output register
// the next request is taken while a finished result still waits in the output register
// synchronous reset clears run counters and output valid; the run rams are not cleared
module run_length_decode_iterator_core (
  input  logic            clk,
  input  logic            rst_n,
  rld_in_if.sink          in_ch,
  rld_out_if.source       out_ch
);

  rld_pkg::dp_cmd_t  dp_cmd;
  rld_pkg::dp_stat_t dp_stat;

  rld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  rld_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_ch.cmd),
    .in_run_count      (in_ch.run_count),
    .in_run_value      (in_ch.run_value),
    .in_take_amount    (in_ch.take_amount),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_element_value (out_ch.element_value),
    .cmd               (dp_cmd),
    .stat              (dp_stat)
  );

endmodule
